FILE: src/ifp_pkg.sv
`default_nettype none

package ifp_pkg;

  localparam int unsigned WinLen     = 11;
  localparam int unsigned SumLen     = 10;
  localparam int unsigned KindCount  = 11;
  localparam int unsigned KindW      = 4;

  localparam logic [7:0] HeaderByte = 8'h55;
  localparam logic [7:0] KindFirst  = 8'h50;
  localparam logic [7:0] KindLast   = 8'h5A;
  localparam logic [7:0] KindAngle  = 8'h53;

  localparam logic CmdPush  = 1'b0;
  localparam logic CmdClear = 1'b1;

  typedef logic [7:0] byte_t;
  typedef byte_t [WinLen-1:0] window_t;

  // control broadcast to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // verdict on the window as it stands after the shift
  typedef struct packed {
    logic             found;
    logic             angle;
    logic [KindW-1:0] kind;
  } frame_info_t;

endpackage

`default_nettype wire

FILE: src/ifp_cell.sv
`default_nettype none

module ifp_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ifp_pkg::cell_ctrl_t ctrl,
  input  wire ifp_pkg::byte_t     d_in,
  output ifp_pkg::byte_t          q
);
  import ifp_pkg::*;

  byte_t data_r;
  byte_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.clear) begin
      data_nxt = '0;
    end else if (ctrl.shift) begin
      data_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign q = data_r;

endmodule

`default_nettype wire

FILE: src/ifp_frame_check.sv
`default_nettype none

module ifp_frame_check (
  input  wire ifp_pkg::window_t   win,
  output ifp_pkg::frame_info_t    info
);
  import ifp_pkg::*;

  byte_t s01, s23, s45, s67, s89;
  byte_t sa, sb, sum;
  byte_t kind_off;
  logic  hdr_ok, kind_ok;

  // balanced adder tree, mod 256
  always_comb begin
    s01 = win[0] + win[1];
    s23 = win[2] + win[3];
    s45 = win[4] + win[5];
    s67 = win[6] + win[7];
    s89 = win[8] + win[9];
    sa  = s01 + s23;
    sb  = s45 + s67;
    sum = sa + sb + s89;
  end

  always_comb begin
    kind_off   = win[1] - KindFirst;
    hdr_ok     = (win[0] == HeaderByte);
    kind_ok    = (win[1] >= KindFirst) && (win[1] <= KindLast);
    info.found = hdr_ok && kind_ok && (sum == win[SumLen]);
    info.angle = info.found && (win[1] == KindAngle);
    info.kind  = info.found ? kind_off[KindW-1:0] : '0;
  end

endmodule

`default_nettype wire

FILE: src/imu_frame_window_parser.sv
`default_nettype none

// byte-wise frame detector for an 11-byte sensor stream. every push item
// shifts rx_byte into a row of eleven byte cells; the window as it stands
// after the shift is checked for header 0x55, a kind byte 0x50..0x5a and a
// mod-256 sum of bytes 0..9 equal to byte 10. each item gives one result:
// found flag, kind (kind byte minus 0x50), the mask of kinds seen since the
// last clear, and the roll, pitch, yaw and temperature words latched from
// the most recent angle frame (kind 0x53), raw and little-endian. a clear
// item zeroes window, latches and mask. one item per cycle while the receiver
// keeps up: the shift and the ten-byte adder tree are combinational and results
// sit in a single output register, which takes a new item in the cycle the old one leaves.
module imu_frame_window_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_cmd,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_frame_found,
  output logic [3:0]              out_frame_kind,
  output logic [10:0]             out_seen_mask,
  output logic signed [15:0]      out_roll_raw,
  output logic signed [15:0]      out_pitch_raw,
  output logic signed [15:0]      out_yaw_raw,
  output logic signed [15:0]      out_temperature_raw
);
  import ifp_pkg::*;

  logic        accept;
  cell_ctrl_t  ctrl;
  window_t     win_q;
  window_t     win_in;
  frame_info_t info;

  logic                 out_valid_r, out_valid_nxt;
  logic                 found_r, found_nxt;
  logic [KindW-1:0]     kind_r, kind_nxt;
  logic [KindCount-1:0] seen_r, seen_nxt;
  logic [15:0]          roll_r, roll_nxt;
  logic [15:0]          pitch_r, pitch_nxt;
  logic [15:0]          yaw_r, yaw_nxt;
  logic [15:0]          temp_r, temp_nxt;

  // the output register frees up in the same cycle its item is taken
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign ctrl.shift = accept && (in_cmd == CmdPush);
  assign ctrl.clear = accept && (in_cmd == CmdClear);

  // each cell loads its upper neighbor; the top cell loads the new byte
  for (genvar i = 0; i < WinLen; i++) begin : g_cell
    if (i == WinLen - 1) begin : g_last
      assign win_in[i] = in_rx_byte;
    end else begin : g_mid
      assign win_in[i] = win_q[i+1];
    end

    ifp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .d_in  (win_in[i]),
      .q     (win_q[i])
    );
  end

  // check the window as it will be after this shift
  ifp_frame_check u_check (
    .win  (win_in),
    .info (info)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    kind_nxt      = kind_r;
    seen_nxt      = seen_r;
    roll_nxt      = roll_r;
    pitch_nxt     = pitch_r;
    yaw_nxt       = yaw_r;
    temp_nxt      = temp_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      out_valid_nxt = 1'b1;
      if (ctrl.clear) begin
        found_nxt = 1'b0;
        kind_nxt  = '0;
        seen_nxt  = '0;
        roll_nxt  = '0;
        pitch_nxt = '0;
        yaw_nxt   = '0;
        temp_nxt  = '0;
      end else begin
        found_nxt = info.found;
        kind_nxt  = info.kind;
        if (info.found) begin
          seen_nxt = seen_r | (KindCount'(1) << info.kind);
        end
        // angle words, little-endian from bytes 2..9
        if (info.angle) begin
          roll_nxt  = {win_in[3], win_in[2]};
          pitch_nxt = {win_in[5], win_in[4]};
          yaw_nxt   = {win_in[7], win_in[6]};
          temp_nxt  = {win_in[9], win_in[8]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      kind_r      <= '0;
      seen_r      <= '0;
      roll_r      <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
      temp_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      kind_r      <= kind_nxt;
      seen_r      <= seen_nxt;
      roll_r      <= roll_nxt;
      pitch_r     <= pitch_nxt;
      yaw_r       <= yaw_nxt;
      temp_r      <= temp_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_found     = found_r;
  assign out_frame_kind      = kind_r;
  assign out_seen_mask       = seen_r;
  assign out_roll_raw        = roll_r;
  assign out_pitch_raw       = pitch_r;
  assign out_yaw_raw         = yaw_r;
  assign out_temperature_raw = temp_r;

endmodule

`default_nettype wire

FILE: dv/imu_frame_window_parser_checker.sv
`timescale 1ns / 100ps

module imu_frame_window_parser_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_cmd,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_frame_found,
  input  logic [3:0]         out_frame_kind,
  input  logic [10:0]        out_seen_mask,
  input  logic signed [15:0] out_roll_raw,
  input  logic signed [15:0] out_pitch_raw,
  input  logic signed [15:0] out_yaw_raw,
  input  logic signed [15:0] out_temperature_raw,
  output int                 mismatch_count,
  output int                 reports_pending
);
  import ifp_pkg::*;

  typedef struct packed {
    logic                 found;
    logic [KindW-1:0]     kind;
    logic [KindCount-1:0] mask;
    logic signed [15:0]   roll;
    logic signed [15:0]   pitch;
    logic signed [15:0]   yaw;
    logic signed [15:0]   temp;
  } frame_report_t;

  byte_t                window_bytes [WinLen];
  logic signed [15:0]   held_roll;
  logic signed [15:0]   held_pitch;
  logic signed [15:0]   held_yaw;
  logic signed [15:0]   held_temp;
  logic [KindCount-1:0] kinds_seen;

  frame_report_t        frame_reports_q [$];
  frame_report_t        observed;
  frame_report_t        wanted;
  int                   fails = 0;

  // shift one item into the window and judge the frame it now ends
  function automatic frame_report_t shift_and_parse(input logic cmd, input byte_t data);
    frame_report_t    res;
    byte_t            sum;
    logic [KindW-1:0] kind;
    int               i;
    res = '0;
    if (cmd == CmdClear) begin
      for (i = 0; i < WinLen; i++) window_bytes[i] = '0;
      held_roll  = '0;
      held_pitch = '0;
      held_yaw   = '0;
      held_temp  = '0;
      kinds_seen = '0;
    end else begin
      for (i = 0; i < WinLen - 1; i++) window_bytes[i] = window_bytes[i+1];
      window_bytes[WinLen-1] = data;
      sum = '0;
      for (i = 0; i < SumLen; i++) sum += window_bytes[i];
      if (window_bytes[0] == HeaderByte && window_bytes[1] >= KindFirst &&
          window_bytes[1] <= KindLast && sum == window_bytes[WinLen-1]) begin
        kind             = KindW'(window_bytes[1] - KindFirst);
        res.found        = 1'b1;
        res.kind         = kind;
        kinds_seen[kind] = 1'b1;
        if (window_bytes[1] == KindAngle) begin
          held_roll  = {window_bytes[3], window_bytes[2]};
          held_pitch = {window_bytes[5], window_bytes[4]};
          held_yaw   = {window_bytes[7], window_bytes[6]};
          held_temp  = {window_bytes[9], window_bytes[8]};
        end
      end
    end
    res.mask  = kinds_seen;
    res.roll  = held_roll;
    res.pitch = held_pitch;
    res.yaw   = held_yaw;
    res.temp  = held_temp;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      void'(shift_and_parse(CmdClear, '0));
      frame_reports_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        observed.found = out_frame_found;
        observed.kind  = out_frame_kind;
        observed.mask  = out_seen_mask;
        observed.roll  = out_roll_raw;
        observed.pitch = out_pitch_raw;
        observed.yaw   = out_yaw_raw;
        observed.temp  = out_temperature_raw;
        if (frame_reports_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected frame report found=%0d kind=%0d mask=%h",
                     $realtime, observed.found, observed.kind, observed.mask);
          fails++;
        end else begin
          wanted = frame_reports_q.pop_front();
          if (observed !== wanted) begin
            if (fails < 10) begin
              $display("%0t: frame report differs", $realtime);
              $display("  exp found=%0d kind=%0d mask=%h roll=%0d pitch=%0d yaw=%0d temp=%0d",
                       wanted.found, wanted.kind, wanted.mask, wanted.roll,
                       wanted.pitch, wanted.yaw, wanted.temp);
              $display("  got found=%0d kind=%0d mask=%h roll=%0d pitch=%0d yaw=%0d temp=%0d",
                       observed.found, observed.kind, observed.mask, observed.roll,
                       observed.pitch, observed.yaw, observed.temp);
            end
            fails++;
          end
        end
      end
      if (in_valid && in_ready)
        frame_reports_q.push_back(shift_and_parse(in_cmd, in_rx_byte));
    end
    mismatch_count  <= fails;
    reports_pending <= frame_reports_q.size();
  end

endmodule

FILE: dv/imu_frame_window_parser_tb.sv
`timescale 1ns / 100ps

module imu_frame_window_parser_tb;
  import ifp_pkg::*;

  // random part length and where the idle-free tail begins
  localparam int RandomItems = 500;
  localparam int TailStart   = 420;
  // long receiver hold-off, counted in receiver cycles after reset
  localparam int HoldStart   = 200;
  localparam int HoldCycles  = 64;
  // single output register, so a short drain is plenty
  localparam int DrainCycles = 10;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_cmd     = CmdPush;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_ready  = 1'b1;
  logic               in_ready;
  logic               out_valid;
  logic               out_frame_found;
  logic [3:0]         out_frame_kind;
  logic [10:0]        out_seen_mask;
  logic signed [15:0] out_roll_raw;
  logic signed [15:0] out_pitch_raw;
  logic signed [15:0] out_yaw_raw;
  logic signed [15:0] out_temperature_raw;

  int mismatch_count;
  int reports_pending;

  // sender bookkeeping
  int   pushed_items  = 0;
  int   send_gap_rate = 0;
  logic calm_tail     = 1'b0;

  always #10 clk = ~clk;

  imu_frame_window_parser u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_found     (out_frame_found),
    .out_frame_kind      (out_frame_kind),
    .out_seen_mask       (out_seen_mask),
    .out_roll_raw        (out_roll_raw),
    .out_pitch_raw       (out_pitch_raw),
    .out_yaw_raw         (out_yaw_raw),
    .out_temperature_raw (out_temperature_raw)
  );

  imu_frame_window_parser_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_found     (out_frame_found),
    .out_frame_kind      (out_frame_kind),
    .out_seen_mask       (out_seen_mask),
    .out_roll_raw        (out_roll_raw),
    .out_pitch_raw       (out_pitch_raw),
    .out_yaw_raw         (out_yaw_raw),
    .out_temperature_raw (out_temperature_raw),
    .mismatch_count      (mismatch_count),
    .reports_pending     (reports_pending)
  );

  // offer one item, maybe after an idle burst, and hold it until accepted
  task automatic send_item(input logic cmd, input byte_t data);
    int gap;
    if (!calm_tail && send_gap_rate != 0 && $urandom_range(0, send_gap_rate) == 0) begin
      // valid drops for a random idle burst, raised again at a later edge only
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_rx_byte <= data;
    // ready read right after the edge is the value the block sampled
    do @(posedge clk); while (!in_ready);
    pushed_items++;
  endtask

  // mostly random words, now and then one of the 16-bit extremes
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one 11-byte frame: header, kind, four little-endian words, checksum
  task automatic send_frame(input byte_t kind_byte, input logic [15:0] w0,
                            input logic [15:0] w1, input logic [15:0] w2,
                            input logic [15:0] w3, input logic good_sum);
    byte_t frame_bytes [WinLen];
    byte_t sum;
    int    i;
    frame_bytes[0] = HeaderByte;
    frame_bytes[1] = kind_byte;
    {frame_bytes[3], frame_bytes[2]} = w0;
    {frame_bytes[5], frame_bytes[4]} = w1;
    {frame_bytes[7], frame_bytes[6]} = w2;
    {frame_bytes[9], frame_bytes[8]} = w3;
    sum = '0;
    for (i = 0; i < SumLen; i++) sum += frame_bytes[i];
    // a broken frame flips one bit of the checksum
    frame_bytes[WinLen-1] = good_sum ? sum : sum ^ byte_t'(1 << $urandom_range(0, 7));
    for (i = 0; i < WinLen; i++) send_item(CmdPush, frame_bytes[i]);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    byte_t kb;
    int    pick;
    int    n;
    int    i;
    int    first_random;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: clear, angle frame with word extremes, header byte as kind,
    // then a clear with a nonzero byte that must be ignored
    send_item(CmdClear, 8'h00);
    send_frame(KindAngle, 16'h8000, 16'h7fff, 16'hffff, 16'h0000, 1'b1);
    send_frame(HeaderByte, 16'h0001, 16'hfffe, 16'h5555, 16'haaaa, 1'b1);
    send_item(CmdClear, 8'hff);

    // random: mostly well-formed frames, plus unknown kinds, bad sums,
    // cut-off frames, noise and the odd clear
    first_random = pushed_items;
    while (pushed_items - first_random < RandomItems) begin
      if ($urandom_range(0, 9) == 0) send_gap_rate = $urandom_range(0, 2) * 4;
      if (pushed_items - first_random >= TailStart) calm_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // good frame, angle kind weighted up so the latches move often
        kb = ($urandom_range(0, 2) == 0) ? KindAngle : byte_t'($urandom_range(KindFirst, KindLast));
        send_frame(kb, pick_word(), pick_word(), pick_word(), pick_word(), 1'b1);
      end else if (pick < 68) begin
        // correct sum but kind byte out of range
        do kb = byte_t'($urandom); while (kb >= KindFirst && kb <= KindLast);
        if ($urandom_range(0, 1) == 0)
          kb = $urandom_range(0, 1) ? byte_t'(KindLast + 1) : byte_t'(KindFirst - 1);
        send_frame(kb, pick_word(), pick_word(), pick_word(), pick_word(), 1'b1);
      end else if (pick < 76) begin
        kb = byte_t'($urandom_range(KindFirst, KindLast));
        send_frame(kb, pick_word(), pick_word(), pick_word(), pick_word(), 1'b0);
      end else if (pick < 84) begin
        // frame cut short after the kind byte
        send_item(CmdPush, HeaderByte);
        send_item(CmdPush, byte_t'($urandom_range(KindFirst, KindLast)));
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) send_item(CmdPush, byte_t'($urandom));
      end else if (pick < 95) begin
        // noise, with plenty of header bytes to tempt false syncs
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
          send_item(CmdPush, ($urandom_range(0, 3) == 0) ? HeaderByte : byte_t'($urandom));
      end else begin
        send_item(CmdClear, byte_t'($urandom));
      end
    end
    in_valid <= 1'b0;

    // drain: wait for every expected report, then let the bench run quiet
    while (reports_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold-off so the output register
  // fills and in_ready drops while the sender keeps offering, none in the tail
  initial begin : result_sink
    int cycles     = 0;
    int stall_rate = 0;
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles % 50 == 0) stall_rate = $urandom_range(0, 2) * 4;
      if (cycles == HoldStart) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm_tail && stall_rate != 0 && $urandom_range(0, stall_rate) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 5);
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
